>>> sv/pss_pkg.sv
// ---------------------------------------------------------------------------
// Polyline step sampler package
// Shared widths, register indexes and the segment record passed from the
// front end to the back end.
// ---------------------------------------------------------------------------
package pss_pkg;

    localparam int COORD_W   = 32;
    localparam int MAG_W     = 32;
    localparam int STEP_W    = 31;
    localparam int EPS_W     = 16;
    localparam int LEN_W     = 33;
    localparam int RAD_W     = 2 * LEN_W;
    localparam int REM_W     = LEN_W + 3;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;
    localparam int CNT_W     = 6;

    // Largest number of parts one segment is cut into.
    localparam int MAX_PARTS = 63;
    localparam int PART_W    = $clog2(MAX_PARTS + 1);
    localparam int DV_W      = STEP_W + PART_W;

    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_DRAW_STEP   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TRAVEL_STEP = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_MIN_STEP    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_EPSILON     = CFG_IDX_W'(3);

    localparam logic [STEP_W-1:0] RST_DRAW_STEP   = STEP_W'(655);
    localparam logic [STEP_W-1:0] RST_TRAVEL_STEP = STEP_W'(3277);
    localparam logic [STEP_W-1:0] RST_MIN_STEP    = STEP_W'(66);
    localparam logic [EPS_W-1:0]  RST_EPSILON     = EPS_W'(1);

    typedef struct packed {
        logic [STEP_W-1:0] draw_step;
        logic [STEP_W-1:0] travel_step;
        logic [STEP_W-1:0] min_step;
        logic [EPS_W-1:0]  epsilon;
    } t_cfg;

    // One classified vertex: either a polyline start or a segment to sample.
    typedef struct packed {
        logic                       store;
        logic signed [COORD_W-1:0]  x0;
        logic signed [COORD_W-1:0]  y0;
        logic [MAG_W-1:0]           adx;
        logic [MAG_W-1:0]           ady;
        logic                       negx;
        logic                       negy;
        logic [STEP_W-1:0]          step;
    } t_seg;

endpackage

>>> sv/pss_if.sv
// ---------------------------------------------------------------------------
// Polyline step sampler channels
// Valid/ready channels for vertices, sampled points and register writes.
// ---------------------------------------------------------------------------
interface pss_vtx_if
    import pss_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic                      first_vertex;
    logic                      draw_mode;

    modport source (output valid, vertex_x, vertex_y, first_vertex, draw_mode,
                    input ready);
    modport sink   (input valid, vertex_x, vertex_y, first_vertex, draw_mode,
                    output ready);
endinterface

interface pss_pt_if
    import pss_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_point;

    modport source (output valid, point_x, point_y, last_point, input ready);
    modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

interface pss_cfg_if
    import pss_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/pss_front.sv
// ---------------------------------------------------------------------------
// Polyline step sampler front end
// Accepts vertices, tracks the previous vertex and classifies each item.
// ---------------------------------------------------------------------------
module pss_front
    import pss_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    pss_vtx_if.sink      i_vtx,
    input  t_cfg         i_cfg,
    output logic         o_push_valid,
    output t_seg         o_push_item,
    input  logic         i_push_ready
);

    logic                      r_have_prev;
    logic signed [COORD_W-1:0] r_prev_x;
    logic signed [COORD_W-1:0] r_prev_y;

    logic signed [COORD_W:0] dx;
    logic signed [COORD_W:0] dy;
    logic signed [COORD_W:0] ndx;
    logic signed [COORD_W:0] ndy;
    logic [STEP_W-1:0]       sel_step;
    logic                    accept;

    assign i_vtx.ready  = i_push_ready;
    assign o_push_valid = i_vtx.valid;
    assign accept       = i_vtx.valid && i_push_ready;

    always_comb begin
        dx  = {i_vtx.vertex_x[COORD_W-1], i_vtx.vertex_x} - {r_prev_x[COORD_W-1], r_prev_x};
        dy  = {i_vtx.vertex_y[COORD_W-1], i_vtx.vertex_y} - {r_prev_y[COORD_W-1], r_prev_y};
        ndx = -dx;
        ndy = -dy;
        sel_step = i_vtx.draw_mode ? i_cfg.draw_step : i_cfg.travel_step;

        o_push_item.store = i_vtx.first_vertex || !r_have_prev;
        o_push_item.x0    = r_prev_x;
        o_push_item.y0    = r_prev_y;
        o_push_item.negx  = dx[COORD_W];
        o_push_item.negy  = dy[COORD_W];
        o_push_item.adx   = dx[COORD_W] ? ndx[MAG_W-1:0] : dx[MAG_W-1:0];
        o_push_item.ady   = dy[COORD_W] ? ndy[MAG_W-1:0] : dy[MAG_W-1:0];
        // A zero step stays zero; a positive one is raised to the floor.
        o_push_item.step  = (sel_step != '0 && sel_step < i_cfg.min_step)
                            ? i_cfg.min_step : sel_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
        end else if (accept) begin
            r_have_prev <= 1'b1;
            r_prev_x    <= i_vtx.vertex_x;
            r_prev_y    <= i_vtx.vertex_y;
        end
    end

endmodule

>>> sv/pss_queue.sv
// ---------------------------------------------------------------------------
// Polyline step sampler segment queue
// Short FIFO that decouples the front end from the back end.
// ---------------------------------------------------------------------------
module pss_queue
    import pss_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    input  t_seg  i_push_item,
    output logic  o_push_ready,
    output logic  o_pop_valid,
    output t_seg  o_pop_item,
    input  logic  i_pop_ready
);

    t_seg              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_cnt != QCNT_W'(QDEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_item   = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

>>> sv/pss_back.sv
// ---------------------------------------------------------------------------
// Polyline step sampler back end
// Measures each segment, picks the part count, walks the points and drops
// points within epsilon of the last kept one.
// ---------------------------------------------------------------------------
module pss_back
    import pss_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_pop_valid,
    input  t_seg     i_pop_item,
    output logic     o_pop_ready,
    input  t_cfg     i_cfg,
    pss_pt_if.source o_pt
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQX, ST_SQY, ST_SUM, ST_SQRT, ST_PSAT, ST_PDIV, ST_PFIN,
        ST_DIV, ST_PT, ST_DIF, ST_SQ, ST_EMIT, ST_NEXT, ST_FLUSH
    } t_state;

    t_state                    r_state;
    t_seg                      r_seg;
    logic [CNT_W-1:0]          r_cnt;
    logic [2*MAG_W-1:0]        r_sqx;
    logic [2*MAG_W-1:0]        r_sqy;
    logic [RAD_W-1:0]          r_rad;
    logic [REM_W-1:0]          r_rem;
    logic [LEN_W-1:0]          r_root;
    logic [2*EPS_W-1:0]        r_eps2;
    logic [DV_W-1:0]           r_n;
    logic [DV_W-1:0]           r_dv;
    logic [PART_W-1:0]         r_q;
    logic [PART_W-1:0]         r_parts;
    logic [MAG_W-1:0]          r_nx;
    logic [MAG_W-1:0]          r_ny;
    logic [PART_W-1:0]         r_remx;
    logic [PART_W-1:0]         r_remy;
    logic [MAG_W-1:0]          r_qdx;
    logic [MAG_W-1:0]          r_qdy;
    logic [PART_W-1:0]         r_rdx;
    logic [PART_W-1:0]         r_rdy;
    logic [MAG_W-1:0]          r_accx;
    logic [MAG_W-1:0]          r_accy;
    logic [PART_W-1:0]         r_arx;
    logic [PART_W-1:0]         r_ary;
    logic [PART_W-1:0]         r_idx;
    logic signed [COORD_W-1:0] r_px;
    logic signed [COORD_W-1:0] r_py;
    logic [EPS_W-1:0]          r_ex;
    logic [EPS_W-1:0]          r_ey;
    logic                      r_cand;
    logic [2*EPS_W-1:0]        r_ex2;
    logic [2*EPS_W-1:0]        r_ey2;
    logic                      r_have_last;
    logic signed [COORD_W-1:0] r_lx;
    logic signed [COORD_W-1:0] r_ly;
    logic                      r_pend;
    logic signed [COORD_W-1:0] r_pend_x;
    logic signed [COORD_W-1:0] r_pend_y;
    logic                      r_ovalid;
    logic signed [COORD_W-1:0] r_ox;
    logic signed [COORD_W-1:0] r_oy;
    logic                      r_olast;

    logic                      out_free;
    logic                      load_out;
    logic [REM_W-1:0]          sq_rem;
    logic [REM_W-1:0]          sq_trial;
    logic [PART_W:0]           dvx;
    logic [PART_W:0]           dvy;
    logic [PART_W:0]           sum_rx;
    logic [PART_W:0]           sum_ry;
    logic signed [COORD_W:0]   ddx;
    logic signed [COORD_W:0]   ddy;
    logic [COORD_W:0]          mdx;
    logic [COORD_W:0]          mdy;
    logic [2*EPS_W:0]          dist2;

    assign out_free    = !r_ovalid || o_pt.ready;
    assign o_pop_ready = (r_state == ST_IDLE);
    assign o_pt.valid      = r_ovalid;
    assign o_pt.point_x    = r_ox;
    assign o_pt.point_y    = r_oy;
    assign o_pt.last_point = r_olast;

    always_comb begin
        sq_rem   = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
        sq_trial = {1'b0, r_root, 2'b01};
        dvx      = {r_remx, r_nx[MAG_W-1]};
        dvy      = {r_remy, r_ny[MAG_W-1]};
        sum_rx   = {1'b0, r_arx} + {1'b0, r_rdx};
        sum_ry   = {1'b0, r_ary} + {1'b0, r_rdy};
        ddx      = {r_px[COORD_W-1], r_px} - {r_lx[COORD_W-1], r_lx};
        ddy      = {r_py[COORD_W-1], r_py} - {r_ly[COORD_W-1], r_ly};
        mdx      = ddx[COORD_W] ? COORD_W'(0) - ddx : ddx;
        mdy      = ddy[COORD_W] ? COORD_W'(0) - ddy : ddy;
        dist2    = {1'b0, r_ex2} + {1'b0, r_ey2};
        // The held point goes out when a newer point replaces it or at flush.
        load_out = out_free && r_pend
                   && ((r_state == ST_EMIT && !(r_cand && dist2 <= {1'b0, r_eps2}))
                       || r_state == ST_FLUSH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_have_last <= 1'b0;
            r_pend      <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (o_pt.ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_pop_valid) begin
                        r_seg <= i_pop_item;
                        if (i_pop_item.store) begin
                            r_have_last <= 1'b0;
                        end else begin
                            r_state <= ST_SQX;
                        end
                    end
                end
                ST_SQX: begin
                    r_sqx   <= r_seg.adx * r_seg.adx;
                    r_state <= ST_SQY;
                end
                ST_SQY: begin
                    r_sqy   <= r_seg.ady * r_seg.ady;
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_rad   <= {2'b00, r_sqx} + {2'b00, r_sqy};
                    r_eps2  <= i_cfg.epsilon * i_cfg.epsilon;
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_cnt   <= CNT_W'(LEN_W - 1);
                    r_state <= ST_SQRT;
                end
                ST_SQRT: begin
                    // One result bit per cycle, two radicand bits brought down.
                    if (sq_rem >= sq_trial) begin
                        r_rem  <= sq_rem - sq_trial;
                        r_root <= {r_root[LEN_W-2:0], 1'b1};
                    end else begin
                        r_rem  <= sq_rem;
                        r_root <= {r_root[LEN_W-2:0], 1'b0};
                    end
                    r_rad <= {r_rad[RAD_W-3:0], 2'b00};
                    if (r_cnt == '0) begin
                        r_state <= ST_PSAT;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                ST_PSAT: begin
                    r_n  <= DV_W'(r_root - 1'b1);
                    r_dv <= DV_W'({r_seg.step, {(PART_W - 1){1'b0}}});
                    r_q  <= '0;
                    if (r_seg.step == '0 || r_root <= LEN_W'(i_cfg.epsilon)) begin
                        r_parts <= PART_W'(1);
                        r_cnt   <= CNT_W'(MAG_W - 1);
                        r_state <= ST_DIV;
                    end else if ({1'b0, DV_W'(r_root - 1'b1)} >=
                                 {r_seg.step, {PART_W{1'b0}}}) begin
                        r_parts <= PART_W'(MAX_PARTS);
                        r_cnt   <= CNT_W'(MAG_W - 1);
                        r_state <= ST_DIV;
                    end else begin
                        r_cnt   <= CNT_W'(PART_W - 1);
                        r_state <= ST_PDIV;
                    end
                    r_nx   <= r_seg.adx;
                    r_ny   <= r_seg.ady;
                    r_remx <= '0;
                    r_remy <= '0;
                end
                ST_PDIV: begin
                    if (r_n >= r_dv) begin
                        r_n <= r_n - r_dv;
                        r_q <= {r_q[PART_W-2:0], 1'b1};
                    end else begin
                        r_q <= {r_q[PART_W-2:0], 1'b0};
                    end
                    r_dv <= r_dv >> 1;
                    if (r_cnt == '0) begin
                        r_state <= ST_PFIN;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                ST_PFIN: begin
                    // Quotient of (L - 1) / step plus one is ceil(L / step).
                    r_parts <= (r_q >= PART_W'(MAX_PARTS)) ? PART_W'(MAX_PARTS)
                                                          : r_q + 1'b1;
                    r_cnt   <= CNT_W'(MAG_W - 1);
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (dvx >= {1'b0, r_parts}) begin
                        r_remx <= PART_W'(dvx - {1'b0, r_parts});
                        r_nx   <= {r_nx[MAG_W-2:0], 1'b1};
                    end else begin
                        r_remx <= dvx[PART_W-1:0];
                        r_nx   <= {r_nx[MAG_W-2:0], 1'b0};
                    end
                    if (dvy >= {1'b0, r_parts}) begin
                        r_remy <= PART_W'(dvy - {1'b0, r_parts});
                        r_ny   <= {r_ny[MAG_W-2:0], 1'b1};
                    end else begin
                        r_remy <= dvy[PART_W-1:0];
                        r_ny   <= {r_ny[MAG_W-2:0], 1'b0};
                    end
                    if (r_cnt == '0) begin
                        r_state <= ST_PT;
                        r_idx   <= '0;
                        r_accx  <= '0;
                        r_accy  <= '0;
                        r_arx   <= '0;
                        r_ary   <= '0;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                ST_PT: begin
                    // The division finished last cycle; capture its result once.
                    if (r_idx == '0) begin
                        r_qdx <= r_nx;
                        r_qdy <= r_ny;
                        r_rdx <= r_remx;
                        r_rdy <= r_remy;
                    end
                    r_px <= r_seg.negx ? r_seg.x0 - $signed(r_accx)
                                       : r_seg.x0 + $signed(r_accx);
                    r_py <= r_seg.negy ? r_seg.y0 - $signed(r_accy)
                                       : r_seg.y0 + $signed(r_accy);
                    r_state <= ST_DIF;
                end
                ST_DIF: begin
                    r_cand <= r_have_last && mdx <= (COORD_W + 1)'(i_cfg.epsilon)
                              && mdy <= (COORD_W + 1)'(i_cfg.epsilon);
                    r_ex    <= mdx[EPS_W-1:0];
                    r_ey    <= mdy[EPS_W-1:0];
                    r_state <= ST_SQ;
                end
                ST_SQ: begin
                    r_ex2   <= r_ex * r_ex;
                    r_ey2   <= r_ey * r_ey;
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (r_cand && dist2 <= {1'b0, r_eps2}) begin
                        r_state <= ST_NEXT;
                    end else if (!r_pend || out_free) begin
                        // A held point is known not to be the last only now.
                        if (r_pend) begin
                            r_ox     <= r_pend_x;
                            r_oy     <= r_pend_y;
                            r_olast  <= 1'b0;
                        end
                        r_pend      <= 1'b1;
                        r_pend_x    <= r_px;
                        r_pend_y    <= r_py;
                        r_lx        <= r_px;
                        r_ly        <= r_py;
                        r_have_last <= 1'b1;
                        r_state     <= ST_NEXT;
                    end
                end
                ST_NEXT: begin
                    if (r_idx == r_parts) begin
                        r_state <= ST_FLUSH;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        if (sum_rx >= {1'b0, r_parts}) begin
                            r_arx  <= PART_W'(sum_rx - {1'b0, r_parts});
                            r_accx <= r_accx + r_qdx + 1'b1;
                        end else begin
                            r_arx  <= sum_rx[PART_W-1:0];
                            r_accx <= r_accx + r_qdx;
                        end
                        if (sum_ry >= {1'b0, r_parts}) begin
                            r_ary  <= PART_W'(sum_ry - {1'b0, r_parts});
                            r_accy <= r_accy + r_qdy + 1'b1;
                        end else begin
                            r_ary  <= sum_ry[PART_W-1:0];
                            r_accy <= r_accy + r_qdy;
                        end
                        r_state <= ST_PT;
                    end
                end
                ST_FLUSH: begin
                    if (!r_pend) begin
                        r_state <= ST_IDLE;
                    end else if (out_free) begin
                        r_ox     <= r_pend_x;
                        r_oy     <= r_pend_y;
                        r_olast  <= 1'b1;
                        r_pend   <= 1'b0;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> sv/polyline_step_sampler.sv
// ---------------------------------------------------------------------------
// Polyline step sampler
// Cuts each polyline segment into evenly spaced points and drops repeats.
// ---------------------------------------------------------------------------
// Vertices enter on i_vtx and sampled points leave on o_pt, all coordinates
// in Q15.16 metres. A vertex flagged first_vertex (or the first after reset)
// only starts a polyline and yields no points. Every later vertex yields the
// points from the previous vertex to itself, cut into min(ceil(L / step), 63)
// parts with L = floor(sqrt(len^2)), or one part if step is zero or L <= epsilon,
// skipping any point within epsilon of the last one kept; last_point marks the
// final point of a vertex. The front end takes one vertex per cycle into a
// two-entry queue while the queue has room. The back end handles one segment
// at a time: squaring, a square root (one root bit per cycle), the part count,
// division by the part count (one bit per cycle), then a walk over the
// candidate points, which an output stall can hold up. Registers are to be
// written on i_cfg, which is always ready, only while the block idles; the
// block itself does not enforce this.
// ---------------------------------------------------------------------------
module polyline_step_sampler
    import pss_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    pss_vtx_if.sink  i_vtx,
    pss_pt_if.source o_pt,
    pss_cfg_if.sink  i_cfg
);

    t_cfg r_cfg;
    logic push_valid;
    logic push_ready;
    t_seg push_item;
    logic pop_valid;
    logic pop_ready;
    t_seg pop_item;

    // Register writes go straight into the register set, so the write channel never stalls.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.draw_step   <= RST_DRAW_STEP;
            r_cfg.travel_step <= RST_TRAVEL_STEP;
            r_cfg.min_step    <= RST_MIN_STEP;
            r_cfg.epsilon     <= RST_EPSILON;
        end else if (i_cfg.valid) begin
            // Values are cut to the register width; unknown indexes are dropped.
            unique case (i_cfg.index)
                REG_DRAW_STEP:   r_cfg.draw_step   <= i_cfg.data[STEP_W-1:0];
                REG_TRAVEL_STEP: r_cfg.travel_step <= i_cfg.data[STEP_W-1:0];
                REG_MIN_STEP:    r_cfg.min_step    <= i_cfg.data[STEP_W-1:0];
                REG_EPSILON:     r_cfg.epsilon     <= i_cfg.data[EPS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Front end: keeps the previous vertex and classifies each item.
    pss_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vtx        (i_vtx),
        .i_cfg        (r_cfg),
        .o_push_valid (push_valid),
        .o_push_item  (push_item),
        .i_push_ready (push_ready)
    );

    // The queue lets the front accept vertices while the back end is busy.
    pss_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_item  (push_item),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_item   (pop_item),
        .i_pop_ready  (pop_ready)
    );

    // Back end: length, part count, point walk and repeat filter.
    pss_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_item  (pop_item),
        .o_pop_ready (pop_ready),
        .i_cfg       (r_cfg),
        .o_pt        (o_pt)
    );

endmodule

>>> sv/pss_checker.sv
// ---------------------------------------------------------------------------
// Polyline step sampler checker
// Port-level checks on the sampler, attached to the top level by bind.
// ---------------------------------------------------------------------------
module pss_checker
    import pss_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_out_valid,
    input logic                      i_out_ready,
    input logic signed [COORD_W-1:0] i_out_x,
    input logic signed [COORD_W-1:0] i_out_y,
    input logic                      i_out_last,
    input logic                      i_cfg_ready
);

    // Reset leaves no point waiting at the output.
    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("point valid after reset");

    // A stalled point holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_x)
            && $stable(i_out_y) && $stable(i_out_last))
        else $error("stalled point changed");

    // Register writes are never back-pressured.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("register port stalled");

    // An offered point carries fully defined values.
    a_out_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !$isunknown({i_out_x, i_out_y, i_out_last}))
        else $error("point carries unknown bits");

endmodule

bind polyline_step_sampler pss_checker u_pss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_pt.valid),
    .i_out_ready (o_pt.ready),
    .i_out_x     (o_pt.point_x),
    .i_out_y     (o_pt.point_y),
    .i_out_last  (o_pt.last_point),
    .i_cfg_ready (i_cfg.ready)
);
